@@ rtl/gqvg_pkg.sv @@
// shared types, constants and arithmetic helpers for the glyph quad vertex generator
`default_nettype none
package gqvg_pkg;

	localparam int unsigned ATLAS_COLUMNS = 16;

	localparam logic [7:0] CODE_END     = 8'd0;
	localparam logic [7:0] CODE_NEWLINE = 8'd10;

	localparam logic MODE_BEGIN = 1'b0;

	localparam logic [16:0] TEX_ONE = 17'd65536;

	localparam logic signed [35:0] POS_MAX_W = 36'sd2147483647;
	localparam logic signed [35:0] POS_MIN_W = -36'sd2147483648;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_GLYPH_SCALE  = 3'd0,
		REG_CELL_WIDTH   = 3'd1,
		REG_CELL_HEIGHT  = 3'd2,
		REG_MARGIN_LEFT  = 3'd3,
		REG_MARGIN_RIGHT = 3'd4,
		REG_TEX_STEP_X   = 3'd5,
		REG_TEX_STEP_Y   = 3'd6,
		REG_UNUSED       = 3'd7
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_BEGIN,
		KIND_END,
		KIND_NEWLINE,
		KIND_GLYPH
	} item_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic       load_item;
		logic       do_begin;
		logic       do_mul;
		logic       do_add;
		logic       load_out;
		logic       commit;
		logic       last;
		logic [1:0] vert_idx;
	} ctrl_cmd_t;

	typedef struct packed {
		item_kind_t in_kind;
		logic       out_free;
	} dp_status_t;

	function automatic logic signed [31:0] sat_pos(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > POS_MAX_W) begin
			r = 32'sh7FFFFFFF;
		end else if (v < POS_MIN_W) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Q.24 to Q1.16 with round half up, clamped to 0..1
	function automatic logic [16:0] tex_round(input logic signed [38:0] q);
		logic signed [38:0] t;
		logic [16:0]        r;
		t = (q + 39'sd128) >>> 8;
		if (q < 0) begin
			r = 17'd0;
		end else if (t > $signed({22'd0, TEX_ONE})) begin
			r = TEX_ONE;
		end else begin
			r = t[16:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/gqvg_ifs.sv @@
// handshake channel interfaces: character items, vertex items, register writes
`default_nettype none
interface gqvg_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [7:0]         char_code;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;

	modport source (output valid, mode, char_code, start_x, start_y, input ready);
	modport sink   (input valid, mode, char_code, start_x, start_y, output ready);
endinterface

interface gqvg_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vert_x;
	logic signed [31:0] vert_y;
	logic [16:0]        tex_u;
	logic [16:0]        tex_v;
	logic               last_vertex;

	modport source (output valid, vert_x, vert_y, tex_u, tex_v, last_vertex, input ready);
	modport sink   (input valid, vert_x, vert_y, tex_u, tex_v, last_vertex, output ready);
endinterface

interface gqvg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/gqvg_datapath.sv @@
// datapath: registers, texel counts, scale multipliers, saturating sums, output register
`default_nettype none
module gqvg_datapath (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire gqvg_pkg::ctrl_cmd_t   cmd,
	output gqvg_pkg::dp_status_t       status,
	input  wire logic                  cfg_we,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [23:0]           cfg_data,
	input  wire logic                  in_mode,
	input  wire logic [7:0]            in_char_code,
	input  wire logic signed [31:0]    in_start_x,
	input  wire logic signed [31:0]    in_start_y,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic signed [31:0]         out_vert_x,
	output logic signed [31:0]         out_vert_y,
	output logic [16:0]                out_tex_u,
	output logic [16:0]                out_tex_v,
	output logic                       out_last_vertex
);
	import gqvg_pkg::*;

	// configuration
	logic [15:0] scale_q;
	logic [8:0]  cw_q;
	logic [8:0]  ch_q;
	logic [7:0]  ml_q;
	logic [7:0]  mr_q;
	logic [23:0] step_x_q;
	logic [23:0] step_y_q;

	// string state
	logic signed [31:0] pen_x_q;
	logic signed [31:0] pen_y_q;
	logic signed [31:0] origin_x_q;
	logic signed [31:0] prev_x_q;
	logic signed [31:0] prev_y_q;
	logic [16:0]        prev_u_q;
	logic [16:0]        prev_v_q;

	// stage 1: texel counts
	logic               nl_s1;
	logic signed [10:0] dx_tex_s1;
	logic [12:0]        u0_tex_s1;
	logic signed [13:0] u1_tex_s1;
	logic [12:0]        v0_tex_s1;
	logic [12:0]        v1_tex_s1;

	// stage 2: products
	logic signed [26:0] dx_mul_s2;
	logic [24:0]        dy_mul_s2;
	logic [36:0]        u0_mul_s2;
	logic signed [37:0] u1_mul_s2;
	logic [36:0]        v0_mul_s2;
	logic [36:0]        v1_mul_s2;

	// stage 3: quad corners
	logic signed [31:0] px1_s3;
	logic signed [31:0] py1_s3;
	logic [16:0]        tu0_s3;
	logic [16:0]        tu1_s3;
	logic [16:0]        tv0_s3;
	logic [16:0]        tv1_s3;

	logic [3:0]         col;
	logic [3:0]         row;
	logic [4:0]         col1;
	logic [4:0]         row1;
	logic [12:0]        u1_hi;
	logic signed [10:0] dx_tex_d;
	logic [12:0]        u0_tex_d;
	logic signed [13:0] u1_tex_d;
	logic [12:0]        v0_tex_d;
	logic [12:0]        v1_tex_d;

	logic signed [27:0] dx_prod;
	logic [24:0]        dy_prod;
	logic [36:0]        u0_prod;
	logic signed [38:0] u1_prod;
	logic [36:0]        v0_prod;
	logic [36:0]        v1_prod;

	logic signed [35:0] px1_sum;
	logic signed [35:0] py1_sum;

	logic signed [31:0] vx_d;
	logic signed [31:0] vy_d;
	logic [16:0]        vu_d;
	logic [16:0]        vv_d;

	// item decode
	always_comb begin
		if (in_mode == MODE_BEGIN) begin
			status.in_kind = KIND_BEGIN;
		end else if (in_char_code == CODE_END) begin
			status.in_kind = KIND_END;
		end else if (in_char_code == CODE_NEWLINE) begin
			status.in_kind = KIND_NEWLINE;
		end else begin
			status.in_kind = KIND_GLYPH;
		end
		status.out_free = !out_valid || out_ready;
	end

	// glyph cell in the atlas: low nibble column, high nibble row
	assign col  = in_char_code[3:0];
	assign row  = in_char_code[7:4];
	assign col1 = {1'b0, col} + 5'd1;
	assign row1 = {1'b0, row} + 5'd1;

	assign dx_tex_d = $signed({2'b00, cw_q}) - $signed({3'b000, ml_q})
		- $signed({3'b000, mr_q});
	assign u0_tex_d = {9'd0, col} * {4'd0, cw_q} + {5'd0, ml_q};
	assign u1_hi    = {8'd0, col1} * {4'd0, cw_q};
	assign u1_tex_d = $signed({1'b0, u1_hi}) - $signed({6'd0, mr_q});
	assign v0_tex_d = {9'd0, row} * {4'd0, ch_q};
	assign v1_tex_d = {8'd0, row1} * {4'd0, ch_q};

	assign dx_prod = $signed({12'd0, scale_q}) * $signed({{17{dx_tex_s1[10]}}, dx_tex_s1});
	assign dy_prod = {9'd0, scale_q} * {16'd0, ch_q};
	assign u0_prod = {13'd0, step_x_q} * {24'd0, u0_tex_s1};
	assign u1_prod = $signed({15'd0, step_x_q}) * $signed({{25{u1_tex_s1[13]}}, u1_tex_s1});
	assign v0_prod = {13'd0, step_y_q} * {24'd0, v0_tex_s1};
	assign v1_prod = {13'd0, step_y_q} * {24'd0, v1_tex_s1};

	// Q8.8 products move to Q16.16 by a shift of 8
	assign px1_sum = {{4{pen_x_q[31]}}, pen_x_q} + {dx_mul_s2[26], dx_mul_s2, 8'h00};
	assign py1_sum = {{4{pen_y_q[31]}}, pen_y_q} + {3'b000, dy_mul_s2, 8'h00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= 16'd256;
			cw_q     <= 9'd8;
			ch_q     <= 9'd8;
			ml_q     <= 8'd8;
			mr_q     <= 8'd8;
			step_x_q <= 24'd32768;
			step_y_q <= 24'd32768;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_GLYPH_SCALE:  scale_q  <= cfg_data[15:0];
				REG_CELL_WIDTH:   cw_q     <= cfg_data[8:0];
				REG_CELL_HEIGHT:  ch_q     <= cfg_data[8:0];
				REG_MARGIN_LEFT:  ml_q     <= cfg_data[7:0];
				REG_MARGIN_RIGHT: mr_q     <= cfg_data[7:0];
				REG_TEX_STEP_X:   step_x_q <= cfg_data;
				REG_TEX_STEP_Y:   step_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			nl_s1     <= (in_char_code == CODE_NEWLINE);
			dx_tex_s1 <= dx_tex_d;
			u0_tex_s1 <= u0_tex_d;
			u1_tex_s1 <= u1_tex_d;
			v0_tex_s1 <= v0_tex_d;
			v1_tex_s1 <= v1_tex_d;
		end
		if (cmd.do_mul) begin
			dx_mul_s2 <= dx_prod[26:0];
			dy_mul_s2 <= dy_prod;
			u0_mul_s2 <= u0_prod;
			u1_mul_s2 <= u1_prod[37:0];
			v0_mul_s2 <= v0_prod;
			v1_mul_s2 <= v1_prod;
		end
		if (cmd.do_add) begin
			px1_s3 <= sat_pos(px1_sum);
			py1_s3 <= sat_pos(py1_sum);
			tu0_s3 <= tex_round({2'b00, u0_mul_s2});
			tu1_s3 <= tex_round({u1_mul_s2[37], u1_mul_s2});
			tv0_s3 <= tex_round({2'b00, v0_mul_s2});
			tv1_s3 <= tex_round({2'b00, v1_mul_s2});
		end
	end

	// vertex select: glyph corners in strip order, newline repeat then pen
	always_comb begin
		if (nl_s1) begin
			if (cmd.vert_idx == 2'd0) begin
				vx_d = prev_x_q;
				vy_d = prev_y_q;
				vu_d = prev_u_q;
				vv_d = prev_v_q;
			end else begin
				vx_d = origin_x_q;
				vy_d = py1_s3;
				vu_d = 17'd0;
				vv_d = 17'd0;
			end
		end else begin
			vx_d = cmd.vert_idx[1] ? px1_s3 : pen_x_q;
			vy_d = cmd.vert_idx[0] ? py1_s3 : pen_y_q;
			vu_d = cmd.vert_idx[1] ? tu1_s3 : tu0_s3;
			vv_d = cmd.vert_idx[0] ? tv1_s3 : tv0_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q    <= '0;
			pen_y_q    <= '0;
			origin_x_q <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			prev_u_q   <= '0;
			prev_v_q   <= '0;
		end else if (cmd.do_begin) begin
			pen_x_q    <= in_start_x;
			origin_x_q <= in_start_x;
			pen_y_q    <= in_start_y;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			prev_u_q   <= '0;
			prev_v_q   <= '0;
		end else if (cmd.commit) begin
			if (nl_s1) begin
				pen_x_q  <= origin_x_q;
				pen_y_q  <= py1_s3;
				prev_x_q <= origin_x_q;
				prev_y_q <= py1_s3;
				prev_u_q <= '0;
				prev_v_q <= '0;
			end else begin
				pen_x_q  <= px1_s3;
				prev_x_q <= px1_s3;
				prev_y_q <= py1_s3;
				prev_u_q <= tu1_s3;
				prev_v_q <= tv1_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_vert_x      <= vx_d;
			out_vert_y      <= vy_d;
			out_tex_u       <= vu_d;
			out_tex_v       <= vv_d;
			out_last_vertex <= cmd.last;
		end
	end

endmodule
`default_nettype wire

@@ rtl/gqvg_ctrl.sv @@
// controller state machine: item accept, compute sequencing, vertex emission
`default_nettype none
module gqvg_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire gqvg_pkg::dp_status_t  status,
	output gqvg_pkg::ctrl_cmd_t        cmd
);
	import gqvg_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        nl_q;
	logic [1:0]  vidx_q;
	logic        accept;
	logic        is_last;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_ready && in_valid;
	// newline gives two vertices, a glyph four
	assign is_last  = nl_q ? (vidx_q == 2'd1) : (vidx_q == 2'd3);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (status.in_kind == KIND_NEWLINE
					|| status.in_kind == KIND_GLYPH)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_ADD;
			ST_ADD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (status.out_free && is_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.vert_idx = vidx_q;
		cmd.last     = is_last;
		case (state_q)
			ST_IDLE: begin
				cmd.load_item = accept && (status.in_kind == KIND_NEWLINE
					|| status.in_kind == KIND_GLYPH);
				cmd.do_begin  = accept && (status.in_kind == KIND_BEGIN);
			end
			ST_MUL:  cmd.do_mul = 1'b1;
			ST_ADD:  cmd.do_add = 1'b1;
			ST_EMIT: begin
				cmd.load_out = status.out_free;
				cmd.commit   = status.out_free && is_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nl_q    <= 1'b0;
			vidx_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			if (cmd.load_item) begin
				nl_q   <= (status.in_kind == KIND_NEWLINE);
				vidx_q <= 2'd0;
			end else if (cmd.load_out) begin
				vidx_q <= vidx_q + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/glyph_quad_vertex_generator_core.sv @@
// top level of the glyph quad vertex generator: controller plus datapath
//
// channel    dir  payload                                       handshake
// item_in    in   mode, char_code, start_x, start_y             valid/ready
// vert_out   out  vert_x, vert_y, tex_u, tex_v, last_vertex     valid/ready
// cfg        in   index (3 bit), data (24 bit)                  valid/ready, always ready
//
// begin and end items are taken in the accept step alone; a glyph passes through accept,
// multiply, sum and four vertex loads, a newline through accept, multiply, sum and two
// vertex loads, in the single controller sequence with the one-deep output register.
// arst_n clears pen, origin and previous vertex to zero and loads register defaults.
// a stalled vert_out holds the sequence at the next vertex load; item_in stays
// low-ready until the last vertex of the item sits in the output register.
`default_nettype none
module glyph_quad_vertex_generator_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gqvg_in_if.sink    item_in,
	gqvg_out_if.source vert_out,
	gqvg_cfg_if.sink   cfg
);
	import gqvg_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg.ready = 1'b1;

	gqvg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (item_in.ready),
		.status   (status),
		.cmd      (cmd)
	);

	gqvg_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.in_mode         (item_in.mode),
		.in_char_code    (item_in.char_code),
		.in_start_x      (item_in.start_x),
		.in_start_y      (item_in.start_y),
		.out_ready       (vert_out.ready),
		.out_valid       (vert_out.valid),
		.out_vert_x      (vert_out.vert_x),
		.out_vert_y      (vert_out.vert_y),
		.out_tex_u       (vert_out.tex_u),
		.out_tex_v       (vert_out.tex_v),
		.out_last_vertex (vert_out.last_vertex)
	);

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// testbench for the glyph quad vertex generator: directed and random text against a predictor
`timescale 1ns / 1ps
module testbench;
	import gqvg_pkg::*;

	localparam logic   MODE_CHAR     = ~MODE_BEGIN;
	localparam int     SETTLE_CYCLES = 12;
	localparam int     IDLE_LIMIT    = 2000;
	localparam int     RANDOM_ITEMS  = 234;
	localparam longint POS_HI        = 64'sd2147483647;
	localparam longint POS_LO        = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [16:0]        u;
		logic [16:0]        v;
		logic               last;
	} vertex_t;

	logic clk;
	logic arst_n;

	gqvg_in_if  item_if();
	gqvg_out_if vert_if();
	gqvg_cfg_if cfg_if();

	glyph_quad_vertex_generator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (item_if),
		.vert_out (vert_if),
		.cfg      (cfg_if)
	);

	// register copy, reset values
	logic [15:0] reg_scale    = 16'd256;
	logic [8:0]  reg_cell_w   = 9'd8;
	logic [8:0]  reg_cell_h   = 9'd8;
	logic [7:0]  reg_margin_l = 8'd8;
	logic [7:0]  reg_margin_r = 8'd8;
	logic [23:0] reg_step_x   = 24'd32768;
	logic [23:0] reg_step_y   = 24'd32768;

	// pen and previous vertex
	logic signed [31:0] pen_x    = '0;
	logic signed [31:0] pen_y    = '0;
	logic signed [31:0] origin_x = '0;
	vertex_t            prev_vertex = '0;

	vertex_t pending_vertices[$];

	int  errors      = 0;
	int  text_items  = 0;
	int  burst_left  = 0;
	int  idle_cycles = 0;
	bit  tx_bursty   = 1'b1;
	bit  rx_stalls   = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: alternating ready and stall runs of random length, or steady ready with stalls off
	initial begin
		bit ready_state;
		int run_left;
		ready_state = 1'b0;
		run_left = 0;
		vert_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!rx_stalls) begin
				ready_state = 1'b1;
			end else if (run_left == 0) begin
				ready_state = ~ready_state;
				run_left = ready_state ? $urandom_range(0, 8) : $urandom_range(0, 9);
			end else begin
				run_left--;
			end
			vert_if.ready <= ready_state;
		end
	end

	task automatic flag_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			flag_mismatch($sformatf("%s got %h, expected %h", name, got, want));
	endtask

	function automatic logic signed [31:0] clamp_pos(input longint v);
		if (v > POS_HI)
			return 32'sh7FFFFFFF;
		if (v < POS_LO)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// Q.24 texel position to Q1.16, round half up, clamped to 0..1
	function automatic logic [16:0] round_tex(input longint q);
		longint r;
		if (q < 0)
			return 17'd0;
		r = (q + 128) >>> 8;
		if (r > longint'(TEX_ONE))
			return TEX_ONE;
		return r[16:0];
	endfunction

	// texel count scaled to screen Q16.16
	function automatic longint scaled_len(input longint texels);
		return longint'(reg_scale) * texels * 256;
	endfunction

	task automatic push_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic [16:0] u, input logic [16:0] v, input logic last);
		vertex_t vx;
		vx.x = x;
		vx.y = y;
		vx.u = u;
		vx.v = v;
		vx.last = last;
		pending_vertices = {pending_vertices, vx};
	endtask

	// updates pen state and queues the vertices one accepted item produces
	task automatic predict_vertices(input logic mode, input logic [7:0] code,
			input logic signed [31:0] sx, input logic signed [31:0] sy);
		longint col, row, cw, ch, ml, mr, stx, sty;
		logic signed [31:0] x0, x1, y0, y1;
		logic [16:0] u0, u1, v0, v1;
		col = longint'(code % ATLAS_COLUMNS);
		row = longint'(code / ATLAS_COLUMNS);
		cw = longint'(reg_cell_w);
		ch = longint'(reg_cell_h);
		ml = longint'(reg_margin_l);
		mr = longint'(reg_margin_r);
		stx = longint'(reg_step_x);
		sty = longint'(reg_step_y);
		if (mode == MODE_BEGIN) begin
			pen_x = sx;
			origin_x = sx;
			pen_y = sy;
			prev_vertex = '0;
		end else if (code == CODE_NEWLINE) begin
			push_vertex(prev_vertex.x, prev_vertex.y, prev_vertex.u, prev_vertex.v, 1'b0);
			pen_x = origin_x;
			pen_y = clamp_pos(longint'(pen_y) + scaled_len(ch));
			push_vertex(pen_x, pen_y, 17'd0, 17'd0, 1'b1);
			prev_vertex.x = pen_x;
			prev_vertex.y = pen_y;
			prev_vertex.u = '0;
			prev_vertex.v = '0;
		end else if (code != CODE_END) begin
			x0 = pen_x;
			x1 = clamp_pos(longint'(pen_x) + scaled_len(cw - ml - mr));
			y0 = pen_y;
			y1 = clamp_pos(longint'(pen_y) + scaled_len(ch));
			u0 = round_tex(stx * (col * cw + ml));
			u1 = round_tex(stx * ((col + 1) * cw - mr));
			v0 = round_tex(sty * (row * ch));
			v1 = round_tex(sty * ((row + 1) * ch));
			push_vertex(x0, y0, u0, v0, 1'b0);
			push_vertex(x0, y1, u0, v1, 1'b0);
			push_vertex(x1, y0, u1, v0, 1'b0);
			push_vertex(x1, y1, u1, v1, 1'b1);
			prev_vertex.x = x1;
			prev_vertex.y = y1;
			prev_vertex.u = u1;
			prev_vertex.v = v1;
			pen_x = x1;
		end
	endtask

	// one item, then the sender's burst and gap pacing
	task automatic send_item(input logic mode, input logic [7:0] code,
			input logic [31:0] sx, input logic [31:0] sy);
		@(negedge clk);
		item_if.mode      <= mode;
		item_if.char_code <= code;
		item_if.start_x   <= sx;
		item_if.start_y   <= sy;
		item_if.valid     <= 1'b1;
		do @(posedge clk); while (!item_if.ready);
		predict_vertices(mode, code, sx, sy);
		text_items++;
		if (tx_bursty) begin
			if (burst_left == 0) begin
				@(negedge clk);
				item_if.valid <= 1'b0;
				repeat ($urandom_range(0, 10)) @(posedge clk);
				burst_left = $urandom_range(0, 16);
			end else begin
				burst_left--;
			end
		end
	endtask

	// hold the sender until every queued vertex is out and the block has settled
	task automatic pause_until_drained();
		@(negedge clk);
		item_if.valid <= 1'b0;
		while (pending_vertices.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [23:0] data);
		@(negedge clk);
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_GLYPH_SCALE:  reg_scale    = data[15:0];
			REG_CELL_WIDTH:   reg_cell_w   = data[8:0];
			REG_CELL_HEIGHT:  reg_cell_h   = data[8:0];
			REG_MARGIN_LEFT:  reg_margin_l = data[7:0];
			REG_MARGIN_RIGHT: reg_margin_r = data[7:0];
			REG_TEX_STEP_X:   reg_step_x   = data;
			REG_TEX_STEP_Y:   reg_step_y   = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic set_registers(input logic [23:0] scale, input logic [23:0] cw,
			input logic [23:0] ch, input logic [23:0] ml, input logic [23:0] mr,
			input logic [23:0] stx, input logic [23:0] sty);
		pause_until_drained();
		write_reg(REG_GLYPH_SCALE, scale);
		write_reg(REG_CELL_WIDTH, cw);
		write_reg(REG_CELL_HEIGHT, ch);
		write_reg(REG_MARGIN_LEFT, ml);
		write_reg(REG_MARGIN_RIGHT, mr);
		write_reg(REG_TEX_STEP_X, stx);
		write_reg(REG_TEX_STEP_Y, sty);
	endtask

	// reset registers: newline before any glyph, code range corners, text after an end
	task automatic test_default_registers();
		send_item(MODE_CHAR, CODE_NEWLINE, '0, '0);
		send_item(MODE_CHAR, 8'd65, '0, '0);
		send_item(MODE_CHAR, 8'd1, '0, '0);
		send_item(MODE_CHAR, 8'd255, '0, '0);
		send_item(MODE_CHAR, 8'd15, '0, '0);
		send_item(MODE_CHAR, 8'd240, '0, '0);
		send_item(MODE_CHAR, CODE_END, '0, '0);
		send_item(MODE_CHAR, 8'd128, '0, '0);
	endtask

	// origins at the position limits, saturating pen moves, newline right after begin
	task automatic test_origin_extremes();
		send_item(MODE_BEGIN, 8'h00, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_item(MODE_CHAR, 8'h55, '0, '0);
		send_item(MODE_CHAR, CODE_NEWLINE, '0, '0);
		send_item(MODE_CHAR, 8'hAA, '0, '0);
		send_item(MODE_BEGIN, 8'hFF, 32'h80000000, 32'h80000000);
		send_item(MODE_CHAR, CODE_NEWLINE, '0, '0);
		send_item(MODE_CHAR, 8'h5A, '0, '0);
		// start fields are don't-care on a character item
		send_item(MODE_CHAR, 8'h7E, 32'h5A5AA5A5, 32'hA5A55A5A);
		pause_until_drained();
	endtask

	// all-ones and all-zero registers, margins wider than the cell, unused index
	task automatic test_register_extremes();
		set_registers(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			24'hFFFFFF, 24'hFFFFFF);
		send_item(MODE_BEGIN, 8'h00, 32'h00000000, 32'h00000000);
		send_item(MODE_CHAR, 8'd255, '0, '0);
		send_item(MODE_CHAR, 8'd1, '0, '0);
		send_item(MODE_CHAR, CODE_NEWLINE, '0, '0);
		set_registers('0, '0, '0, '0, '0, '0, '0);
		send_item(MODE_BEGIN, 8'h00, 32'h12345678, 32'hEDCBA987);
		send_item(MODE_CHAR, 8'h77, '0, '0);
		send_item(MODE_CHAR, CODE_NEWLINE, '0, '0);
		set_registers(24'h000100, 24'd1, 24'd1, 24'd255, 24'd255, 24'h100000, 24'h100000);
		send_item(MODE_CHAR, 8'h0F, '0, '0);
		send_item(MODE_CHAR, 8'hF0, '0, '0);
		pause_until_drained();
		write_reg(REG_UNUSED, 24'hABCDEF);
		send_item(MODE_CHAR, 8'h33, '0, '0);
	endtask

	// strings of glyphs and newlines under changing registers, with some noise
	task automatic test_random_strings(input int target);
		int strings_done;
		int len;
		int cw;
		int ch;
		logic [31:0] sx;
		logic [31:0] sy;
		logic [7:0]  code;
		strings_done = 0;
		target += text_items;
		while (text_items < target) begin
			if (strings_done % 6 == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					set_registers(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
						24'($urandom), 24'($urandom), 24'($urandom));
				end else begin
					cw = $urandom_range(4, 24);
					ch = $urandom_range(4, 24);
					set_registers(24'($urandom_range(128, 768)), 24'(cw), 24'(ch),
						24'($urandom_range(0, cw / 4)), 24'($urandom_range(0, cw / 4)),
						24'((1 << 20) / cw), 24'((1 << 20) / ch));
				end
				tx_bursty = $urandom_range(0, 3) != 0;
				rx_stalls = $urandom_range(0, 3) != 0;
			end
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4))
					send_item(1'($urandom_range(0, 1)), 8'($urandom), $urandom, $urandom);
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					sx = $urandom;
					sy = $urandom;
				end else begin
					sx = $urandom_range(0, 32'h04000000) - 32'h02000000;
					sy = $urandom_range(0, 32'h04000000) - 32'h02000000;
				end
				send_item(MODE_BEGIN, 8'($urandom), sx, sy);
				len = $urandom_range(1, 12);
				repeat (len) begin
					code = 8'($urandom_range(1, 255));
					if ($urandom_range(0, 7) == 0)
						code = CODE_NEWLINE;
					send_item(MODE_CHAR, code, $urandom, $urandom);
				end
				// some strings are left open
				if ($urandom_range(0, 9) != 0)
					send_item(MODE_CHAR, CODE_END, $urandom, $urandom);
			end
			if ($urandom_range(0, 11) == 0)
				pause_until_drained();
			strings_done++;
		end
	endtask

	// each vertex against the oldest queued prediction
	always @(posedge clk) begin
		vertex_t want;
		if (arst_n && vert_if.valid && vert_if.ready) begin
			if (pending_vertices.size() == 0) begin
				flag_mismatch($sformatf("unexpected vertex x=%h y=%h", vert_if.vert_x,
					vert_if.vert_y));
			end else begin
				want = pending_vertices.pop_front();
				check_field("vert_x", want.x, vert_if.vert_x);
				check_field("vert_y", want.y, vert_if.vert_y);
				check_field("tex_u", 32'(want.u), 32'(vert_if.tex_u));
				check_field("tex_v", 32'(want.v), 32'(vert_if.tex_v));
				check_field("last_vertex", 32'(want.last), 32'(vert_if.last_vertex));
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (vert_if.valid && vert_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: %0d vertices still expected", pending_vertices.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.mode = MODE_BEGIN;
		item_if.char_code = CODE_END;
		item_if.start_x = '0;
		item_if.start_y = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_GLYPH_SCALE;
		cfg_if.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_registers();
		test_origin_extremes();
		test_register_extremes();
		test_random_strings(RANDOM_ITEMS);

		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/gqvg_pkg.sv
rtl/gqvg_ifs.sv
rtl/gqvg_datapath.sv
rtl/gqvg_ctrl.sv
rtl/glyph_quad_vertex_generator_core.sv
sim/testbench.sv
